// ===== hw/rtl/nfa_pkg.sv =====
package nfa_pkg;

    localparam int SECTORS_DEF      = 16;
    localparam int SECTOR_BYTES_DEF = 512;

    localparam logic [7:0] ERASED = 8'hFF;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_ERASE = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_RANGE      = 3'd2;
    localparam logic [2:0] ST_NOT_ERASED = 3'd3;
    localparam logic [2:0] ST_BLOCKED    = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_RANGE   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] start_address;
        logic [15:0] length;
        logic [7:0]  write_data;
        logic [7:0]  sector_index;
        logic [7:0]  sector_count;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] status;
        logic       last;
        logic       error_event;
    } t_out_beat;

endpackage

// ===== hw/rtl/nfa_store.sv =====
module nfa_store #(
    parameter  int DEPTH = nfa_pkg::SECTORS_DEF * nfa_pkg::SECTOR_BYTES_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/nfa_ctrl.sv =====
module nfa_ctrl #(
    parameter  int SECTORS      = nfa_pkg::SECTORS_DEF,
    parameter  int SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF,
    localparam int ARRAY_BYTES  = SECTORS * SECTOR_BYTES,
    localparam int AW           = $clog2(ARRAY_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nfa_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nfa_pkg::t_out_beat o_out_data,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [7:0]         o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [7:0]         i_mem_rdata
);

    localparam int ABW = $clog2(ARRAY_BYTES + 1);
    localparam int CW  = ((ABW > 16) ? ABW : 16) + 1;
    localparam int SBW = $clog2(SECTOR_BYTES);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_ERASE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state             r_state,    n_state;
    logic [AW-1:0]      r_addr,     n_addr;
    logic [SBW-1:0]     r_byte,     n_byte;
    logic [7:0]         r_sec_left, n_sec_left;
    logic [1:0]         r_sticky,   n_sticky;
    logic [AW-1:0]      r_offset,   n_offset;
    logic               r_abort,    n_abort;
    logic               r_is_wr,    n_is_wr;
    logic [7:0]         r_wdata,    n_wdata;
    logic               r_last,     n_last;
    nfa_pkg::t_out_beat r_res,      n_res;
    nfa_pkg::t_out_beat r_out,      n_out;
    logic               r_out_vld,  n_out_vld;

    nfa_pkg::t_out_beat res;
    logic               emit;
    logic               out_free;
    logic [CW-1:0]      start_ext, len_ext, off_ext, off_inc_ext, rw_addr_ext;
    logic               restart, range_bad, erase_bad, rw_last;
    logic [AW-1:0]      off_eff, rw_addr, erase_base;
    logic [8:0]         sidx_ext, secs_ext;

    assign out_free  = !r_out_vld || i_out_ready;
    assign start_ext = CW'(i_in_data.start_address);
    assign len_ext   = CW'(i_in_data.length);
    assign off_ext   = CW'(r_offset);
    assign restart   = off_ext >= len_ext;
    assign off_eff   = restart ? '0 : r_offset;
    assign off_inc_ext = CW'(off_eff) + CW'(1);
    assign rw_last     = off_inc_ext == len_ext;
    assign rw_addr_ext = start_ext + CW'(off_eff);
    assign rw_addr     = rw_addr_ext[AW-1:0];
    assign range_bad   = (start_ext >= CW'(ARRAY_BYTES))
                      || ((start_ext + len_ext) > CW'(ARRAY_BYTES));
    assign sidx_ext    = 9'(i_in_data.sector_index);
    assign secs_ext    = 9'(SECTORS);
    assign erase_bad   = (sidx_ext >= secs_ext)
                      || ((secs_ext - sidx_ext) < 9'(i_in_data.sector_count));
    assign erase_base  = AW'(i_in_data.sector_index) * AW'(SECTOR_BYTES);

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_byte     = r_byte;
        n_sec_left = r_sec_left;
        n_sticky   = r_sticky;
        n_offset   = r_offset;
        n_abort    = r_abort;
        n_is_wr    = r_is_wr;
        n_wdata    = r_wdata;
        n_last     = r_last;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_out_ready;
        res        = '0;
        emit       = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_addr;
        o_mem_wdata = nfa_pkg::ERASED;
        o_mem_raddr = rw_addr;

        case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
                n_addr   = r_addr + AW'(1);
                if (r_addr == AW'(ARRAY_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.func == nfa_pkg::FUNC_NOP) begin
                        emit = 1'b1;
                    end else if (r_sticky != nfa_pkg::ERR_NONE) begin
                        res.status = nfa_pkg::ST_BLOCKED;
                        res.last   = 1'b1;
                        emit       = 1'b1;
                    end else if (i_in_data.func == nfa_pkg::FUNC_ERASE) begin
                        n_offset = '0;
                        n_abort  = 1'b0;
                        if (erase_bad) begin
                            n_sticky        = nfa_pkg::ERR_INVALID;
                            res.status      = nfa_pkg::ST_INVALID;
                            res.last        = 1'b1;
                            res.error_event = 1'b1;
                            emit            = 1'b1;
                        end else if (i_in_data.sector_count == 8'd0) begin
                            res.last = 1'b1;
                            emit     = 1'b1;
                        end else begin
                            n_addr     = erase_base;
                            n_byte     = '0;
                            n_sec_left = i_in_data.sector_count;
                            n_state    = S_ERASE;
                        end
                    end else if (i_in_data.length == 16'd0) begin
                        n_sticky        = nfa_pkg::ERR_INVALID;
                        n_offset        = '0;
                        n_abort         = 1'b0;
                        res.status      = nfa_pkg::ST_INVALID;
                        res.last        = 1'b1;
                        res.error_event = 1'b1;
                        emit            = 1'b1;
                    end else if (range_bad) begin
                        n_sticky        = nfa_pkg::ERR_RANGE;
                        n_offset        = '0;
                        n_abort         = 1'b0;
                        res.status      = nfa_pkg::ST_RANGE;
                        res.last        = 1'b1;
                        res.error_event = 1'b1;
                        emit            = 1'b1;
                    end else begin
                        n_addr   = rw_addr;
                        n_is_wr  = i_in_data.func == nfa_pkg::FUNC_WRITE;
                        n_wdata  = i_in_data.write_data;
                        n_last   = rw_last;
                        n_abort  = restart ? 1'b0 : r_abort;
                        n_offset = rw_last ? '0 : off_inc_ext[AW-1:0];
                        n_state  = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                res.last = r_last;
                if (!r_is_wr) begin
                    res.read_data = i_mem_rdata;
                end else if (r_abort) begin
                    res.status = nfa_pkg::ST_NOT_ERASED;
                end else if (i_mem_rdata != nfa_pkg::ERASED) begin
                    res.status = nfa_pkg::ST_NOT_ERASED;
                    n_abort    = 1'b1;
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = r_wdata;
                end
                if (r_last) begin
                    n_abort = 1'b0;
                end
                emit = 1'b1;
            end
            S_ERASE: begin
                o_mem_we = 1'b1;
                n_addr   = r_addr + AW'(1);
                if (r_byte == SBW'(SECTOR_BYTES - 1)) begin
                    n_byte     = '0;
                    n_sec_left = r_sec_left - 8'd1;
                    if (r_sec_left == 8'd1) begin
                        res.last = 1'b1;
                        emit     = 1'b1;
                    end
                end else begin
                    n_byte = r_byte + SBW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            if (out_free) begin
                n_out     = res;
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_sticky  <= nfa_pkg::ERR_NONE;
            r_offset  <= '0;
            r_abort   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_sticky  <= n_sticky;
            r_offset  <= n_offset;
            r_abort   <= n_abort;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_sec_left <= n_sec_left;
        r_is_wr    <= n_is_wr;
        r_wdata    <= n_wdata;
        r_last     <= n_last;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/nor_flash_array_model.sv =====
// NOR flash array, SECTORS x SECTOR_BYTES bytes, erased to 0xFF. After reset the block
// sweeps the whole array, one byte a cycle, before it takes its first beat. In a read
// or write beat the byte is fetched from the single-port-read array in the accept cycle
// and checked, returned or programmed in the next. An erase, once accepted, writes one
// byte per cycle over its sectors. Zero-length, out-of-range, bad-sector, blocked and
// unused-code beats are answered on acceptance, with no array access. A result held
// in the output register lets the next beat in; a second result waits until the
// first is taken.
module nor_flash_array_model #(
    parameter int SECTORS      = nfa_pkg::SECTORS_DEF,
    parameter int SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nfa_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nfa_pkg::t_out_beat o_out_data
);

    localparam int ARRAY_BYTES = SECTORS * SECTOR_BYTES;
    localparam int AW          = $clog2(ARRAY_BYTES);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    nfa_ctrl #(
        .SECTORS      (SECTORS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    nfa_store #(
        .DEPTH (ARRAY_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== hw/rtl/nfa_checker.sv =====
module nfa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input nfa_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input nfa_pkg::t_out_beat o_out_data
);

    logic r_seen_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_err <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_out_data.error_event) begin
            r_seen_err <= 1'b1;
        end
    end

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed under stall");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("beat presented straight after reset");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_event |->
            o_out_data.last && o_out_data.read_data == 8'd0
            && (o_out_data.status == nfa_pkg::ST_INVALID
                || o_out_data.status == nfa_pkg::ST_RANGE))
        else $error("malformed error event beat");

    // once sticky, only blocked beats or unused-code beats may follow
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_err |->
            !o_out_data.error_event
            && ((o_out_data.status == nfa_pkg::ST_BLOCKED && o_out_data.last)
                || (o_out_data.status == nfa_pkg::ST_OK && !o_out_data.last)))
        else $error("operation not blocked after sticky error");

endmodule

bind nor_flash_array_model nfa_checker u_nfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== test/tb_nor_flash_array_model.sv =====
`timescale 1ns / 100ps

module tb_nor_flash_array_model;

    localparam int ARRAY_BYTES  = nfa_pkg::SECTORS_DEF * nfa_pkg::SECTOR_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;

    logic               i_clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    nfa_pkg::t_in_beat  in_data   = '0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    nfa_pkg::t_out_beat out_data;

    nor_flash_array_model uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // predicted array contents and control state
    logic [7:0]  flash_img [ARRAY_BYTES];
    logic [1:0]  sticky_err;
    int unsigned beat_pos;
    logic        wr_aborted;

    nfa_pkg::t_out_beat pending_results [$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count;
    int unsigned n_read, n_write, n_erase, n_not_erased, n_blocked, n_sticky;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic nfa_pkg::t_out_beat flash_predict(nfa_pkg::t_in_beat b);
        nfa_pkg::t_out_beat r;
        logic [1:0]         err;
        int unsigned        st, ln, si, sc, addr;
        r   = '0;
        err = nfa_pkg::ERR_NONE;
        st  = b.start_address;
        ln  = b.length;
        si  = b.sector_index;
        sc  = b.sector_count;
        if (b.func == nfa_pkg::FUNC_NOP) return r;
        if (sticky_err != nfa_pkg::ERR_NONE) begin
            r.status = nfa_pkg::ST_BLOCKED;
            r.last   = 1'b1;
            return r;
        end
        if (b.func == nfa_pkg::FUNC_ERASE) begin
            if (si >= nfa_pkg::SECTORS_DEF || nfa_pkg::SECTORS_DEF - si < sc)
                err = nfa_pkg::ERR_INVALID;
        end else if (ln == 0) begin
            err = nfa_pkg::ERR_INVALID;
        end else if (st >= ARRAY_BYTES || ln > ARRAY_BYTES - st) begin
            err = nfa_pkg::ERR_RANGE;
        end
        if (err != nfa_pkg::ERR_NONE) begin
            sticky_err    = err;
            beat_pos      = 0;
            wr_aborted    = 1'b0;
            r.status      = (err == nfa_pkg::ERR_INVALID) ? nfa_pkg::ST_INVALID
                                                          : nfa_pkg::ST_RANGE;
            r.last        = 1'b1;
            r.error_event = 1'b1;
            return r;
        end
        if (b.func == nfa_pkg::FUNC_ERASE) begin
            for (int i = si * nfa_pkg::SECTOR_BYTES_DEF;
                 i < (si + sc) * nfa_pkg::SECTOR_BYTES_DEF; i++)
                flash_img[i] = nfa_pkg::ERASED;
            beat_pos   = 0;
            wr_aborted = 1'b0;
            r.last     = 1'b1;
            return r;
        end
        if (beat_pos >= ln) begin
            beat_pos   = 0;
            wr_aborted = 1'b0;
        end
        addr = st + beat_pos;
        if (b.func == nfa_pkg::FUNC_READ) begin
            r.read_data = flash_img[addr];
        end else if (wr_aborted) begin
            r.status = nfa_pkg::ST_NOT_ERASED;
        end else if (flash_img[addr] != nfa_pkg::ERASED) begin
            wr_aborted = 1'b1;
            r.status   = nfa_pkg::ST_NOT_ERASED;
        end else begin
            flash_img[addr] = b.write_data;
        end
        if (beat_pos + 1 == ln) begin
            r.last     = 1'b1;
            beat_pos   = 0;
            wr_aborted = 1'b0;
        end else begin
            beat_pos++;
        end
        return r;
    endfunction

    function automatic nfa_pkg::t_in_beat noise_beat();
        nfa_pkg::t_in_beat b;
        b.func          = 2'($urandom_range(3));
        b.start_address = 16'($urandom_range(16'hFFFF));
        b.length        = 16'($urandom_range(16'hFFFF));
        b.write_data    = 8'($urandom_range(255));
        b.sector_index  = 8'($urandom_range(255));
        b.sector_count  = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic nfa_pkg::t_in_beat make_beat(logic [1:0] f, int st, int ln,
                                                    logic [7:0] wd, int si, int sc);
        nfa_pkg::t_in_beat b;
        b.func          = f;
        b.start_address = 16'(st);
        b.length        = 16'(ln);
        b.write_data    = wd;
        b.sector_index  = 8'(si);
        b.sector_count  = 8'(sc);
        return b;
    endfunction

    task automatic send_beat(input nfa_pkg::t_in_beat b);
        nfa_pkg::t_out_beat want;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge i_clk); while (!in_ready);
        want = flash_predict(b);
        pending_results.push_back(want);
        case (b.func)
            nfa_pkg::FUNC_READ:  n_read++;
            nfa_pkg::FUNC_WRITE: n_write++;
            nfa_pkg::FUNC_ERASE: n_erase++;
            default: ;
        endcase
        if (want.status == nfa_pkg::ST_NOT_ERASED) n_not_erased++;
        if (want.status == nfa_pkg::ST_BLOCKED) n_blocked++;
        if (want.error_event) n_sticky++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result checker and receiver back-pressure
    always @(posedge i_clk) begin : result_check
        nfa_pkg::t_out_beat want;
        if (rst_n && out_ready && out_valid) begin
            if (pending_results.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected beat: data %02h st %0d last %b ev %b",
                             out_data.read_data, out_data.status, out_data.last,
                             out_data.error_event);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_data.read_data !== want.read_data || out_data.status !== want.status ||
                    out_data.last !== want.last || out_data.error_event !== want.error_event) begin
                    if (fail_count < 10)
                        $display("mismatch: exp data %02h st %0d last %b ev %b, got %02h %0d %b %b",
                                 want.read_data, want.status, want.last, want.error_event,
                                 out_data.read_data, out_data.status, out_data.last,
                                 out_data.error_event);
                    fail_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    task automatic test_erased_after_reset();
        send_beat(make_beat(nfa_pkg::FUNC_READ, 0, 1, 8'h00, 0, 0));
        send_beat(make_beat(nfa_pkg::FUNC_READ, ARRAY_BYTES - 1, 1, 8'h00, 0, 0));
        for (int k = 0; k < 2; k++)
            send_beat(make_beat(nfa_pkg::FUNC_READ, 40, 2, 8'h00, 0, 0));
        drain_results();
    endtask

    task automatic test_program_abort();
        send_beat(make_beat(nfa_pkg::FUNC_WRITE, 16, 3, 8'h00, 0, 0));
        send_beat(make_beat(nfa_pkg::FUNC_WRITE, 16, 3, 8'hA5, 0, 0));
        send_beat(make_beat(nfa_pkg::FUNC_WRITE, 16, 3, nfa_pkg::ERASED, 0, 0));
        // 15 programs, 16 refuses, 17 and 18 stay aborted
        for (int k = 0; k < 4; k++)
            send_beat(make_beat(nfa_pkg::FUNC_WRITE, 15, 4, 8'h3C, 255, 255));
        for (int k = 0; k < 4; k++)
            send_beat(make_beat(nfa_pkg::FUNC_READ, 15, 4, 8'h00, 0, 0));
        drain_results();
    endtask

    task automatic test_beat_counter();
        send_beat(make_beat(nfa_pkg::FUNC_READ, 100, 4, 8'h00, 0, 0));
        send_beat(make_beat(nfa_pkg::FUNC_READ, 100, 4, 8'h00, 0, 0));
        // offset 2 against length 2 restarts the count; read and write share it
        send_beat(make_beat(nfa_pkg::FUNC_WRITE, 200, 2, 8'h81, 0, 0));
        send_beat(make_beat(nfa_pkg::FUNC_READ, 200, 2, 8'h00, 0, 0));
        drain_results();
    endtask

    task automatic test_unused_func();
        send_beat(make_beat(nfa_pkg::FUNC_READ, 16, 2, 8'h00, 0, 0));
        send_beat(make_beat(nfa_pkg::FUNC_NOP, 16'hFFFF, 16'hFFFF, 8'hFF, 255, 255));
        send_beat(make_beat(nfa_pkg::FUNC_READ, 16, 2, 8'h00, 0, 0));
        drain_results();
    endtask

    task automatic test_erase();
        send_beat(make_beat(nfa_pkg::FUNC_ERASE, 0, 0, 8'h00, 0, 0));
        send_beat(make_beat(nfa_pkg::FUNC_ERASE, 0, 0, 8'h00, nfa_pkg::SECTORS_DEF - 1, 1));
        send_beat(make_beat(nfa_pkg::FUNC_ERASE, 0, 0, 8'h00, 0, nfa_pkg::SECTORS_DEF));
        send_beat(make_beat(nfa_pkg::FUNC_READ, 16, 1, 8'h00, 0, 0));
        drain_results();
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall,
                                       input int unsigned n_beats);
        nfa_pkg::t_in_beat b;
        int unsigned       pick, st, ln, beats, sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < n_beats) begin
            pick = $urandom_range(99);
            b    = noise_beat();
            if (pick < 5) begin
                b.func = nfa_pkg::FUNC_ERASE;
                st = ($urandom_range(1) == 0) ? 0 : $urandom_range(nfa_pkg::SECTORS_DEF - 1);
                if ($urandom_range(9) == 0) ln = nfa_pkg::SECTORS_DEF - st;
                else ln = $urandom_range((nfa_pkg::SECTORS_DEF - st < 2)
                                         ? nfa_pkg::SECTORS_DEF - st : 2);
                b.sector_index = 8'(st);
                b.sector_count = 8'(ln);
                send_beat(b);
                sent++;
            end else if (pick < 10) begin
                b.func = nfa_pkg::FUNC_NOP;
                send_beat(b);
            end else begin
                b.func = ($urandom_range(1) == 0) ? nfa_pkg::FUNC_READ : nfa_pkg::FUNC_WRITE;
                pick = $urandom_range(99);
                if (pick < 80) ln = $urandom_range(1, 8);
                else if (pick < 95) ln = $urandom_range(9, 64);
                else ln = $urandom_range(1, 16);
                if (pick >= 95) st = ARRAY_BYTES - ln;
                else if ($urandom_range(9) < 7) st = $urandom_range(255);
                else st = $urandom_range(ARRAY_BYTES - ln);
                // occasionally cut a transfer short
                beats = ($urandom_range(9) == 0) ? $urandom_range(1, ln) : ln;
                b.start_address = 16'(st);
                b.length        = 16'(ln);
                for (int k = 0; k < beats; k++) begin
                    b.write_data = ($urandom_range(4) == 0) ? nfa_pkg::ERASED
                                                             : 8'($urandom_range(255));
                    send_beat(b);
                    sent++;
                end
            end
        end
        drain_results();
    endtask

    task automatic test_sticky_error();
        nfa_pkg::t_in_beat b;
        int unsigned       kind;
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        kind = $urandom_range(3);
        b    = noise_beat();
        b.func = ($urandom_range(1) == 0) ? nfa_pkg::FUNC_READ : nfa_pkg::FUNC_WRITE;
        case (kind)
            0: b.length = '0;
            1: begin
                b.start_address = 16'($urandom_range(ARRAY_BYTES, 16'hFFFF));
                b.length        = 16'($urandom_range(1, 16'hFFFF));
            end
            2: begin
                b.start_address = 16'($urandom_range(ARRAY_BYTES - 1));
                b.length        = 16'($urandom_range(ARRAY_BYTES - b.start_address + 1,
                                                     16'hFFFF));
            end
            default: begin
                b.func = nfa_pkg::FUNC_ERASE;
                if ($urandom_range(1) == 0) begin
                    b.sector_index = 8'($urandom_range(nfa_pkg::SECTORS_DEF, 255));
                end else begin
                    b.sector_index = 8'($urandom_range(nfa_pkg::SECTORS_DEF - 1));
                    b.sector_count = 8'($urandom_range(
                        nfa_pkg::SECTORS_DEF - b.sector_index + 1, 255));
                end
            end
        endcase
        send_beat(b);
        repeat (30) send_beat(noise_beat());
        drain_results();
    endtask

    initial begin : main
        for (int i = 0; i < ARRAY_BYTES; i++) flash_img[i] = nfa_pkg::ERASED;
        sticky_err = nfa_pkg::ERR_NONE;
        beat_pos   = 0;
        wr_aborted = 1'b0;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        test_erased_after_reset();
        test_program_abort();
        test_beat_counter();
        test_unused_func();
        test_erase();
        test_random_traffic(0, 0, 150);
        test_random_traffic(82, 0, 150);
        test_random_traffic(0, 82, 150);
        test_random_traffic(9, 9, 150);
        test_sticky_error();

        $display("beats: %0d read, %0d write, %0d erase; %0d refused on programmed cells",
                 n_read, n_write, n_erase, n_not_erased);
        $display("sticky errors raised: %0d, beats blocked after it: %0d", n_sticky, n_blocked);
        fail_count += pending_results.size();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
